/* hdl/lpfe_pkg.sv */
// Shared constants, types and configuration codes of the light pulse frame encoder.
// Used by every module of the block; depends on nothing.
package lpfe_pkg;

	localparam int BLOCK_BYTES     = 32;
	localparam int MAX_FRAME_BYTES = 1024;

	localparam int LEN_W      = 11;
	localparam int BIT_TIME_W = 15;
	localparam int TIME_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int BLK_LOG    = $clog2(BLOCK_BYTES);
	localparam int BLK_CNT_W  = $clog2(BLOCK_BYTES + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int STEP_W          = 6;
	localparam int HDR_PULSES      = 4;
	localparam int BYTE_PULSES     = 2 * BYTE_W;
	localparam int START_LAST_STEP = HDR_PULSES + 2 * BYTE_PULSES - 1;
	localparam int BYTE_LAST_STEP  = BYTE_PULSES - 1;
	localparam int GAP_STEP        = BYTE_PULSES;

	localparam logic [TIME_W-1:0] WAKE_MARK  = TIME_W'(50);
	localparam logic [TIME_W-1:0] WAKE_SPACE = TIME_W'(100);

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_BYTE  = 1'b1;

	localparam logic LEVEL_MARK  = 1'b1;
	localparam logic LEVEL_SPACE = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIT_TIME,
		CFG_HDR_MARK,
		CFG_HDR_SPACE,
		CFG_BLOCK_GAP
	} cfg_reg_t;

	typedef enum logic {
		CMD_START,
		CMD_BYTE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] byte_a;
		logic [BYTE_W-1:0] byte_b;
		logic              gap;
	} cmd_t;

	typedef struct packed {
		logic [BIT_TIME_W-1:0] bit_time;
		logic [TIME_W-1:0]     one_time;
		logic [TIME_W-1:0]     hdr_mark;
		logic [TIME_W-1:0]     hdr_space;
		logic [TIME_W-1:0]     gap_time;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

/* hdl/lpfe_front.sv */
// Front end: accepts input items, tracks the open frame and queues pulse commands.
// Depends on lpfe_pkg.
module lpfe_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        func,
	input  logic [lpfe_pkg::LEN_W-1:0]  frame_length,
	input  logic [lpfe_pkg::BYTE_W-1:0] data_byte,
	input  lpfe_pkg::fifo_stat_t        fifo_stat,
	output logic                        push,
	output lpfe_pkg::cmd_t              push_cmd
);
	import lpfe_pkg::*;

	logic                 open_q, open_d;
	logic [LEN_W-1:0]     total_q, total_d;
	logic [BLK_CNT_W-1:0] blk_q, blk_d;

	logic                 accept;
	logic [LEN_W-1:0]     len_sat;
	logic [LEN_W:0]       len_round;
	logic [BLK_LOG-1:0]   rem_low;
	logic [BLK_CNT_W-1:0] rem_full;
	logic [BLK_CNT_W-1:0] first_blk;
	logic [LEN_W-1:0]     total_dec;
	logic [BLK_CNT_W-1:0] blk_dec;
	logic [BLK_CNT_W-1:0] next_blk;

	assign item_stall = fifo_stat.full;
	assign accept     = item_valid && !fifo_stat.full;

	assign len_sat   = (frame_length > LEN_W'(MAX_FRAME_BYTES)) ?
		LEN_W'(MAX_FRAME_BYTES) : frame_length;
	assign len_round = {1'b0, len_sat} + (LEN_W + 1)'(BLOCK_BYTES - 1);
	assign rem_low   = len_sat[BLK_LOG-1:0];
	assign rem_full  = (rem_low == '0) ? BLK_CNT_W'(BLOCK_BYTES) : BLK_CNT_W'(rem_low);
	assign first_blk = (len_sat < LEN_W'(BLOCK_BYTES)) ?
		BLK_CNT_W'(len_sat) : BLK_CNT_W'(BLOCK_BYTES);

	assign total_dec = total_q - LEN_W'(1);
	assign blk_dec   = blk_q - BLK_CNT_W'(1);
	assign next_blk  = (total_dec < LEN_W'(BLOCK_BYTES)) ?
		BLK_CNT_W'(total_dec) : BLK_CNT_W'(BLOCK_BYTES);

	always_comb begin
		open_d   = open_q;
		total_d  = total_q;
		blk_d    = blk_q;
		push     = 1'b0;
		push_cmd = '0;
		if (accept) begin
			if (func == FUNC_START) begin
				if (len_sat == '0) begin
					open_d  = 1'b0;
					total_d = '0;
					blk_d   = '0;
				end else begin
					open_d          = 1'b1;
					total_d         = len_sat;
					blk_d           = first_blk;
					push            = 1'b1;
					push_cmd.kind   = CMD_START;
					push_cmd.byte_a = BYTE_W'(len_round >> BLK_LOG);
					push_cmd.byte_b = BYTE_W'(rem_full);
				end
			end else if (open_q) begin
				push            = 1'b1;
				push_cmd.kind   = CMD_BYTE;
				push_cmd.byte_a = data_byte;
				total_d         = total_dec;
				if (total_dec == '0) begin
					open_d = 1'b0;
					blk_d  = '0;
				end else if (blk_dec == '0) begin
					push_cmd.gap = 1'b1;
					blk_d        = next_blk;
				end else begin
					blk_d = blk_dec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			total_q <= '0;
			blk_q   <= '0;
		end else begin
			open_q  <= open_d;
			total_q <= total_d;
			blk_q   <= blk_d;
		end
	end

	a_open_counts: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (total_q != '0) && (blk_q != '0) && (BLK_CNT_W'(BLOCK_BYTES) >= blk_q))
		else $error("open frame with empty byte counts");

	a_closed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (total_q == '0) && (blk_q == '0))
		else $error("closed frame left byte counts");

endmodule

/* hdl/lpfe_cmd_fifo.sv */
// Short command queue between the front end and the pulse sequencer.
// Depends on lpfe_pkg.
module lpfe_cmd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lpfe_pkg::cmd_t       push_cmd,
	input  logic                 pop,
	output lpfe_pkg::cmd_t       head_cmd,
	output lpfe_pkg::fifo_stat_t stat
);
	import lpfe_pkg::*;

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign head_cmd   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("command queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("command queue underrun");

endmodule

/* hdl/lpfe_back.sv */
// Pulse sequencer: expands queued commands into mark or space pulses, one per cycle while not stalled.
// Depends on lpfe_pkg; pulses leave through an output register, and the downstream stall holds the sequencer.
module lpfe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lpfe_pkg::cfg_t              cfg,
	input  lpfe_pkg::fifo_stat_t        fifo_stat,
	input  lpfe_pkg::cmd_t              head_cmd,
	output logic                        pop,
	output logic                        pulse_valid,
	input  logic                        pulse_stall,
	output logic                        pulse_level,
	output logic [lpfe_pkg::TIME_W-1:0] pulse_time,
	output logic                        last_pulse
);
	import lpfe_pkg::*;

	logic              busy_q;
	cmd_t              cmd_q;
	logic [STEP_W-1:0] step_q;

	logic              out_valid_q;
	logic              out_level_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_last_q;

	logic              advance;
	logic              emit;
	logic              is_last;
	logic [STEP_W-1:0] bit_step;
	logic [BYTE_W-1:0] sel_byte;
	logic              bit_val;
	logic              level;
	logic [TIME_W-1:0] dur;
	logic [TIME_W-1:0] unit_time;

	assign advance   = !out_valid_q || !pulse_stall;
	assign emit      = busy_q && advance;
	assign unit_time = TIME_W'(cfg.bit_time);

	assign bit_step = (cmd_q.kind == CMD_START) ? (step_q - STEP_W'(HDR_PULSES)) : step_q;
	assign sel_byte = ((cmd_q.kind == CMD_START) && bit_step[4]) ? cmd_q.byte_b : cmd_q.byte_a;
	assign bit_val  = sel_byte[~bit_step[3:1]];

	always_comb begin
		level = bit_step[0] ? LEVEL_SPACE : LEVEL_MARK;
		dur   = (!bit_step[0] && bit_val) ? cfg.one_time : unit_time;
		if (cmd_q.kind == CMD_START) begin
			is_last = (step_q == STEP_W'(START_LAST_STEP));
			unique case (step_q)
				STEP_W'(0): begin
					level = LEVEL_MARK;
					dur   = WAKE_MARK;
				end
				STEP_W'(1): begin
					level = LEVEL_SPACE;
					dur   = WAKE_SPACE;
				end
				STEP_W'(2): begin
					level = LEVEL_MARK;
					dur   = cfg.hdr_mark;
				end
				STEP_W'(3): begin
					level = LEVEL_SPACE;
					dur   = cfg.hdr_space;
				end
				default: begin
				end
			endcase
		end else begin
			is_last = cmd_q.gap ? (step_q == STEP_W'(GAP_STEP)) :
				(step_q == STEP_W'(BYTE_LAST_STEP));
			if (step_q == STEP_W'(GAP_STEP)) begin
				level = LEVEL_SPACE;
				dur   = cfg.gap_time;
			end
		end
	end

	assign pop = !fifo_stat.empty && (!busy_q || (emit && is_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (emit) begin
			out_level_q <= level;
			out_time_q  <= dur;
			out_last_q  <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (emit) begin
				step_q <= step_q + STEP_W'(1);
				if (is_last) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	assign pulse_valid = out_valid_q;
	assign pulse_level = out_level_q;
	assign pulse_time  = out_time_q;
	assign last_pulse  = out_last_q;

	a_start_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cmd_q.kind == CMD_START)) |-> (step_q <= STEP_W'(START_LAST_STEP)))
		else $error("start sequence ran past its last pulse");

	a_byte_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cmd_q.kind == CMD_BYTE)) |-> (step_q <= STEP_W'(GAP_STEP)))
		else $error("byte sequence ran past its last pulse");

endmodule

/* hdl/light_pulse_frame_encoder_core.sv */
// Top level of the light pulse frame encoder: configuration registers and the
// front end, command queue and pulse sequencer. Depends on lpfe_pkg and all lpfe_ modules.
//
// Each accepted item yields its pulses one per clock while pulse_stall is low, from a
// registered output: a start item gives 36 pulses (wake-up, header, block count,
// last-block count), a payload byte 16 pulses, or 17 when a block gap follows. The
// front end takes one item per cycle while the four-word command queue has room;
// ignored items and zero-length starts push no command. The sustained rate of a frame
// is set by the sequencer emitting one pulse per cycle while pulse_stall is low.
// Configuration is written through cfg_we/cfg_index/cfg_data and takes effect at once.
module light_pulse_frame_encoder_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lpfe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpfe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            func,
	input  logic [lpfe_pkg::LEN_W-1:0]      frame_length,
	input  logic [lpfe_pkg::BYTE_W-1:0]     data_byte,
	output logic                            pulse_valid,
	input  logic                            pulse_stall,
	output logic                            pulse_level,
	output logic [lpfe_pkg::TIME_W-1:0]     pulse_time,
	output logic                            last_pulse
);
	import lpfe_pkg::*;

	logic [BIT_TIME_W-1:0] bit_time_q;
	logic [TIME_W-1:0]     hdr_mark_q;
	logic [TIME_W-1:0]     hdr_space_q;
	logic [TIME_W-1:0]     gap_time_q;
	logic [TIME_W:0]       triple;

	cfg_t       cfg;
	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q  <= BIT_TIME_W'(1000);
			hdr_mark_q  <= TIME_W'(2000);
			hdr_space_q <= TIME_W'(1000);
			gap_time_q  <= TIME_W'(10000);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BIT_TIME:  bit_time_q  <= cfg_data[BIT_TIME_W-1:0];
				CFG_HDR_MARK:  hdr_mark_q  <= cfg_data;
				CFG_HDR_SPACE: hdr_space_q <= cfg_data;
				CFG_BLOCK_GAP: gap_time_q  <= cfg_data;
				default:       bit_time_q  <= bit_time_q;
			endcase
		end
	end

	// saturate a one mark of three bit times
	assign triple = {(TIME_W + 1 - BIT_TIME_W)'(0), bit_time_q}
		+ {(TIME_W - BIT_TIME_W)'(0), bit_time_q, 1'b0};

	assign cfg.bit_time  = bit_time_q;
	assign cfg.one_time  = triple[TIME_W] ? '1 : triple[TIME_W-1:0];
	assign cfg.hdr_mark  = hdr_mark_q;
	assign cfg.hdr_space = hdr_space_q;
	assign cfg.gap_time  = gap_time_q;

	lpfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.frame_length (frame_length),
		.data_byte    (data_byte),
		.fifo_stat    (fifo_stat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	lpfe_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (fifo_stat)
	);

	lpfe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.fifo_stat   (fifo_stat),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.pulse_valid (pulse_valid),
		.pulse_stall (pulse_stall),
		.pulse_level (pulse_level),
		.pulse_time  (pulse_time),
		.last_pulse  (last_pulse)
	);

endmodule

/* bench/tb.sv */
// Self-checking bench for light_pulse_frame_encoder_core: drives frame starts and
// payload words, predicts every mark/space pulse and compares it on the output side.
// Depends on lpfe_pkg and the encoder RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct {
		logic              func;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
	} enc_word_t;

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] ptime;
		logic              last;
	} pulse_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic                  func = 1'b0;
	logic [LEN_W-1:0]      frame_length = '0;
	logic [BYTE_W-1:0]     data_byte = '0;
	logic                  pulse_valid;
	logic                  pulse_stall = 1'b1;
	logic                  pulse_level;
	logic [TIME_W-1:0]     pulse_time;
	logic                  last_pulse;

	enc_word_t words_to_send[$];
	pulse_t    pulses_due[$];
	pulse_t    burst[$];

	logic [BIT_TIME_W-1:0] bit_unit = 15'd1000;
	logic [TIME_W-1:0]     hdr_mark_t = 16'd2000;
	logic [TIME_W-1:0]     hdr_space_t = 16'd1000;
	logic [TIME_W-1:0]     gap_t = 16'd10000;

	logic             frame_open = 1'b0;
	logic [LEN_W-1:0] total_left = '0;
	logic [5:0]       block_left = '0;
	logic [7:0]       blocks_left = '0;

	int send_idle_pct = 31;
	int recv_stall_pct = 31;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	logic word_taken = 1'b0;

	light_pulse_frame_encoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.func(func),
		.frame_length(frame_length),
		.data_byte(data_byte),
		.pulse_valid(pulse_valid),
		.pulse_stall(pulse_stall),
		.pulse_level(pulse_level),
		.pulse_time(pulse_time),
		.last_pulse(last_pulse)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic add_pulse(logic lvl, logic [TIME_W-1:0] t);
		pulse_t p;
		p.level = lvl;
		p.ptime = t;
		p.last = 1'b0;
		burst.push_back(p);
	endtask

	task automatic add_byte_cells(logic [BYTE_W-1:0] v);
		logic [16:0]       triple;
		logic [TIME_W-1:0] one_t;
		int                b;
		triple = 17'(bit_unit) * 17'd3;
		one_t = (triple > 17'd65535) ? 16'hFFFF : triple[TIME_W-1:0];
		for (b = BYTE_W - 1; b >= 0; b--) begin
			add_pulse(LEVEL_MARK, v[b] ? one_t : TIME_W'(bit_unit));
			add_pulse(LEVEL_SPACE, TIME_W'(bit_unit));
		end
	endtask

	// Advance the frame state for one accepted word and queue its pulses.
	task automatic encode_word(logic f, logic [LEN_W-1:0] len_in, logic [BYTE_W-1:0] v);
		int len;
		int blocks;
		int rem;
		burst.delete();
		if (f == FUNC_START) begin
			len = len_in;
			if (len > MAX_FRAME_BYTES)
				len = MAX_FRAME_BYTES;
			if (len == 0) begin
				frame_open = 1'b0;
				total_left = '0;
				block_left = '0;
				blocks_left = '0;
			end else begin
				blocks = (len + BLOCK_BYTES - 1) / BLOCK_BYTES;
				rem = len % BLOCK_BYTES;
				if (rem == 0)
					rem = BLOCK_BYTES;
				frame_open = 1'b1;
				total_left = LEN_W'(len);
				block_left = 6'((len < BLOCK_BYTES) ? len : BLOCK_BYTES);
				blocks_left = 8'(blocks);
				add_pulse(LEVEL_MARK, WAKE_MARK);
				add_pulse(LEVEL_SPACE, WAKE_SPACE);
				add_pulse(LEVEL_MARK, hdr_mark_t);
				add_pulse(LEVEL_SPACE, hdr_space_t);
				add_byte_cells(8'(blocks));
				add_byte_cells(8'(rem));
			end
		end else if (frame_open) begin
			add_byte_cells(v);
			if (total_left > 0)
				total_left--;
			if (block_left > 0)
				block_left--;
			if (total_left == 0) begin
				frame_open = 1'b0;
				block_left = '0;
				blocks_left = '0;
			end else if (block_left == 0) begin
				add_pulse(LEVEL_SPACE, gap_t);
				if (blocks_left > 0)
					blocks_left--;
				block_left = 6'((total_left < BLOCK_BYTES) ? total_left : BLOCK_BYTES);
			end
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			pulses_due.push_back(burst[i]);
	endtask

	task automatic push_start(int len);
		enc_word_t w;
		w.func = FUNC_START;
		w.len = LEN_W'(len);
		w.data = BYTE_W'($urandom_range(0, 255));
		words_to_send.push_back(w);
	endtask

	task automatic push_byte(int v);
		enc_word_t w;
		w.func = FUNC_BYTE;
		w.len = LEN_W'($urandom_range(0, 2047));
		w.data = BYTE_W'(v);
		words_to_send.push_back(w);
	endtask

	// Mostly complete frames with random content, some noise and cut-off frames.
	task automatic queue_traffic(int n);
		int sent;
		int r;
		int len;
		int nb;
		int i;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_byte($urandom_range(0, 255));
				sent += 1;
			end else if (r < 12) begin
				push_start(0);
				sent += 1;
			end else if (r < 20) begin
				push_start($urandom_range(1, 2047));
				nb = $urandom_range(0, 3);
				for (i = 0; i < nb; i++)
					push_byte($urandom_range(0, 255));
				sent += 1 + nb;
			end else begin
				len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 40);
				push_start(len);
				for (i = 0; i < len; i++)
					push_byte($urandom_range(0, 255));
				sent += 1 + len;
			end
		end
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BIT_TIME: bit_unit = val[BIT_TIME_W-1:0];
			CFG_HDR_MARK: hdr_mark_t = val;
			CFG_HDR_SPACE: hdr_space_t = val;
			CFG_BLOCK_GAP: gap_t = val;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [15:0] bt, logic [15:0] hm, logic [15:0] hs, logic [15:0] gp);
		write_reg(CFG_BIT_TIME, bt);
		write_reg(CFG_HDR_MARK, hm);
		write_reg(CFG_HDR_SPACE, hs);
		write_reg(CFG_BLOCK_GAP, gp);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (words_to_send.size() != 0 || item_valid || pulses_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin : send_words
		enc_word_t w;
		if (!item_valid || word_taken) begin
			if (arst_n && words_to_send.size() != 0 &&
			    $urandom_range(0, 99) >= send_idle_pct) begin
				w = words_to_send.pop_front();
				item_valid <= 1'b1;
				func <= w.func;
				frame_length <= w.len;
				data_byte <= w.data;
			end else
				item_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pulse_stall <= 1'b1;
		end else
			pulse_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_pulses
		pulse_t due;
		word_taken = item_valid && !item_stall;
		if (arst_n) begin
			if (word_taken)
				encode_word(func, frame_length, data_byte);
			if (pulse_valid && !pulse_stall) begin
				if (pulses_due.size() == 0) begin
					$error("pulse with nothing expected: level %0d time %0d last %0d",
					       pulse_level, pulse_time, last_pulse);
					errors++;
				end else begin
					due = pulses_due.pop_front();
					if (pulse_level !== due.level) begin
						$error("pulse_level: expected %0d, got %0d", due.level, pulse_level);
						errors++;
					end
					if (pulse_time !== due.ptime) begin
						$error("pulse_time: expected %0d, got %0d", due.ptime, pulse_time);
						errors++;
					end
					if (last_pulse !== due.last) begin
						$error("last_pulse: expected %0d, got %0d", due.last, last_pulse);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (pulse_valid && !pulse_stall) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		push_byte(8'hA5);
		push_start(0);
		push_start(1);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_start(2047);
		push_byte(8'hFF);
		push_start(BLOCK_BYTES);
		push_byte(8'h80);
		push_start(3);
		push_byte(8'h01);
		push_start(0);
		push_byte(8'h7F);
		push_start(MAX_FRAME_BYTES);
		push_start(64);
		push_start(31);
		push_byte(8'h55);
		push_start(MAX_FRAME_BYTES + 1);
		push_byte(8'hC3);
		wait_drained();

		write_all(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		queue_traffic(10);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		queue_traffic(10);
		wait_drained();
		send_idle_pct = 31;
		recv_stall_pct = 31;

		write_all(16'd21845, 16'd1234, 16'd4321, 16'd777);
		hold_asked++;
		push_start(40);
		repeat (40) push_byte($urandom_range(0, 255));
		queue_traffic(10);
		wait_drained();

		write_all(16'd1, 16'd1, 16'd1, 16'd1);
		queue_traffic(10);
		wait_drained();

		write_all(16'($urandom_range(1, 21845)), 16'($urandom_range(0, 65535)),
		          16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		queue_traffic(10);
		wait_drained();

		repeat (40) @(negedge clk);
		if (errors == 0 && pulses_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* sim.f */
hdl/lpfe_pkg.sv
hdl/lpfe_front.sv
hdl/lpfe_cmd_fifo.sv
hdl/lpfe_back.sv
hdl/light_pulse_frame_encoder_core.sv
bench/tb.sv
